@@ sv/sst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the step-and-settle position trimmer.
// No dependencies; imported by every module of the block.
package sst_pkg;

    // Field widths
    localparam int DIST_W   = 13;
    localparam int TOL_W    = 10;
    localparam int MODE_W   = 2;
    localparam int SPEED_W  = 9;
    localparam int GAIN_W   = 10;
    localparam int CNT8_W   = 8;
    localparam int VEL_W    = 10;
    localparam int TOTAL_W  = 16;
    localparam int CMD_W    = 2;
    localparam int OC_W     = 3;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int PROD_W   = GAIN_W + DIST_W;

    // Timeout in control ticks
    localparam logic [TOTAL_W-1:0] TIMEOUT_TICKS = 16'd300;
    localparam logic [SPEED_W-1:0] MIN_SPEED     = 9'd10;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PATH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd3;

    // Outcomes
    localparam logic [OC_W-1:0] OC_NONE     = 3'd0;
    localparam logic [OC_W-1:0] OC_STARTED  = 3'd1;
    localparam logic [OC_W-1:0] OC_BUSY     = 3'd2;
    localparam logic [OC_W-1:0] OC_NO_DATA  = 3'd3;
    localparam logic [OC_W-1:0] OC_IN_TOL   = 3'd4;
    localparam logic [OC_W-1:0] OC_TIMEOUT  = 3'd5;
    localparam logic [OC_W-1:0] OC_STEP_LIM = 3'd6;

    // Phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TUNE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0]  target_distance;
        logic [TOL_W-1:0]   tolerance;
        logic [MODE_W-1:0]  motion_mode;
        logic [SPEED_W-1:0] max_speed;
        logic [GAIN_W-1:0]  speed_gain;
        logic [CNT8_W-1:0]  step_limit;
        logic [CNT8_W-1:0]  move_ticks;
        logic [CNT8_W-1:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               path_seen;
        logic               have_sample;
        logic [DIST_W-1:0]  last_range;
        logic               moving;
        logic               settling;
        logic [TOTAL_W-1:0] total_ticks;
        logic [CNT8_W-1:0]  phase_ticks;
        logic [CNT8_W-1:0]  steps_done;
        logic [VEL_W-1:0]   held_vx;
        logic [VEL_W-1:0]   held_vy;
        logic               done_flag;
    } state_t;

    typedef struct packed {
        logic               drive_valid;
        logic [VEL_W-1:0]   vel_x;
        logic [VEL_W-1:0]   vel_y;
        logic               done_res;
        logic [OC_W-1:0]    outcome;
    } result_t;

endpackage

@@ sv/sst_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the trimmer: eight write-only registers.
// Depends on sst_pkg.
module sst_cfg
    import sst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Load the addressed register on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_distance <= 13'd200;
            cfg_reg.tolerance       <= 10'd10;
            cfg_reg.motion_mode     <= 2'd0;
            cfg_reg.max_speed       <= 9'd50;
            cfg_reg.speed_gain      <= 10'd128;
            cfg_reg.step_limit      <= 8'd50;
            cfg_reg.move_ticks      <= 8'd2;
            cfg_reg.settle_ticks    <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET:   cfg_reg.target_distance <= cfg_wdata;
                REG_TOL:      cfg_reg.tolerance       <= cfg_wdata[TOL_W-1:0];
                REG_MODE:     cfg_reg.motion_mode     <= cfg_wdata[MODE_W-1:0];
                REG_MAX_SPD:  cfg_reg.max_speed       <= cfg_wdata[SPEED_W-1:0];
                REG_GAIN:     cfg_reg.speed_gain      <= cfg_wdata[GAIN_W-1:0];
                REG_STEP_LIM: cfg_reg.step_limit      <= cfg_wdata[CNT8_W-1:0];
                REG_MOVE:     cfg_reg.move_ticks      <= cfg_wdata[CNT8_W-1:0];
                REG_SETTLE:   cfg_reg.settle_ticks    <= cfg_wdata[CNT8_W-1:0];
                default:      cfg_reg.target_distance <= cfg_reg.target_distance;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/sst_step.sv @@
`timescale 1ns / 1ps
// Single-pass event update of the trimmer: next state and result for one beat.
// Depends on sst_pkg.
module sst_step
    import sst_pkg::*;
(
    input  cfg_t               cfg,
    input  state_t             st,
    input  logic [CMD_W-1:0]   command,
    input  logic [DIST_W-1:0]  value,
    output state_t             st_next,
    output result_t            res
);

    logic [TOTAL_W-1:0] total_inc;
    logic [CNT8_W-1:0]  phase_inc;
    logic [CNT8_W-1:0]  steps_inc;
    logic               err_pos;
    logic [DIST_W-1:0]  err_abs;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-9:0]  speed_raw;
    logic [PROD_W-9:0]  speed_floor;
    logic [SPEED_W-1:0] speed;
    logic               positive;
    logic [VEL_W-1:0]   vel;
    logic [VEL_W-1:0]   new_vx;
    logic [VEL_W-1:0]   new_vy;

    // Saturating counters
    assign total_inc = (st.total_ticks == '1) ? st.total_ticks
                                              : st.total_ticks + TOTAL_W'(1);
    assign phase_inc = (st.phase_ticks == '1) ? st.phase_ticks
                                              : st.phase_ticks + CNT8_W'(1);
    assign steps_inc = (st.steps_done == '1) ? st.steps_done
                                             : st.steps_done + CNT8_W'(1);

    // Error, speed and signed velocity for the next step
    assign err_pos   = st.last_range > cfg.target_distance;
    assign err_abs   = err_pos ? st.last_range - cfg.target_distance
                               : cfg.target_distance - st.last_range;
    assign product   = PROD_W'(cfg.speed_gain) * PROD_W'(err_abs);
    assign speed_raw = product[PROD_W-1:8];

    always_comb
    begin
        speed_floor = (speed_raw < (PROD_W-8)'(MIN_SPEED)) ? (PROD_W-8)'(MIN_SPEED) : speed_raw;
        if (speed_floor > (PROD_W-8)'(cfg.max_speed))
            speed = cfg.max_speed;
        else
            speed = speed_floor[SPEED_W-1:0];
    end

    assign positive = cfg.motion_mode[1] ^ ~err_pos ? 1'b0 : 1'b1;
    assign vel      = positive ? VEL_W'(speed) : VEL_W'(0) - VEL_W'(speed);
    assign new_vx   = cfg.motion_mode[0] ? '0 : vel;
    assign new_vy   = cfg.motion_mode[0] ? vel : '0;

    // Event dispatch
    always_comb
    begin
        st_next         = st;
        res.drive_valid = 1'b0;
        res.vel_x       = '0;
        res.vel_y       = '0;
        res.outcome     = OC_NONE;

        case (command)
            CMD_TICK:
            begin
                if (st.phase == PH_TUNE)
                begin
                    st_next.total_ticks = total_inc;
                    if (total_inc > TIMEOUT_TICKS ||
                        (cfg.step_limit != '0 && st.steps_done >= cfg.step_limit))
                    begin
                        st_next.phase     = PH_DONE;
                        st_next.moving    = 1'b0;
                        st_next.settling  = 1'b0;
                        st_next.done_flag = 1'b1;
                        res.drive_valid   = 1'b1;
                        res.outcome       = (total_inc > TIMEOUT_TICKS) ? OC_TIMEOUT
                                                                         : OC_STEP_LIM;
                    end
                    else if (st.moving)
                    begin
                        res.drive_valid = 1'b1;
                        if (phase_inc >= cfg.move_ticks)
                        begin
                            st_next.moving      = 1'b0;
                            st_next.settling    = 1'b1;
                            st_next.phase_ticks = '0;
                        end
                        else
                        begin
                            st_next.phase_ticks = phase_inc;
                            res.vel_x           = st.held_vx;
                            res.vel_y           = st.held_vy;
                        end
                    end
                    else if (st.settling)
                    begin
                        st_next.phase_ticks = phase_inc;
                        res.drive_valid     = 1'b1;
                        if (phase_inc >= cfg.settle_ticks && st.have_sample)
                        begin
                            if (err_abs <= DIST_W'(cfg.tolerance))
                            begin
                                st_next.phase     = PH_DONE;
                                st_next.moving    = 1'b0;
                                st_next.settling  = 1'b0;
                                st_next.done_flag = 1'b1;
                                res.outcome       = OC_IN_TOL;
                            end
                            else
                            begin
                                st_next.held_vx     = new_vx;
                                st_next.held_vy     = new_vy;
                                st_next.moving      = 1'b1;
                                st_next.settling    = 1'b0;
                                st_next.phase_ticks = '0;
                                st_next.steps_done  = steps_inc;
                                res.vel_x           = new_vx;
                                res.vel_y           = new_vy;
                            end
                        end
                    end
                end
            end

            CMD_SAMPLE:
            begin
                st_next.last_range  = value;
                st_next.have_sample = 1'b1;
                if (st.path_seen && st.phase == PH_IDLE)
                begin
                    st_next.phase       = PH_TUNE;
                    st_next.total_ticks = '0;
                    st_next.phase_ticks = '0;
                    st_next.moving      = 1'b0;
                    st_next.settling    = 1'b1;
                    st_next.held_vx     = '0;
                    st_next.held_vy     = '0;
                    res.drive_valid     = 1'b1;
                    res.outcome         = OC_STARTED;
                end
            end

            CMD_PATH:
            begin
                if (value[0] && !st.path_seen)
                begin
                    st_next.path_seen = 1'b1;
                    if (st.phase == PH_IDLE && st.have_sample)
                    begin
                        st_next.phase       = PH_TUNE;
                        st_next.total_ticks = '0;
                        st_next.phase_ticks = '0;
                        st_next.moving      = 1'b0;
                        st_next.settling    = 1'b1;
                        st_next.held_vx     = '0;
                        st_next.held_vy     = '0;
                        res.drive_valid     = 1'b1;
                        res.outcome         = OC_STARTED;
                    end
                end
            end

            default:
            begin
                if (st.phase == PH_TUNE)
                    res.outcome = OC_BUSY;
                else if (!st.have_sample)
                    res.outcome = OC_NO_DATA;
                else
                begin
                    st_next.phase       = PH_TUNE;
                    st_next.total_ticks = '0;
                    st_next.phase_ticks = '0;
                    st_next.moving      = 1'b0;
                    st_next.settling    = 1'b1;
                    st_next.held_vx     = '0;
                    st_next.held_vy     = '0;
                    st_next.steps_done  = '0;
                    st_next.done_flag   = 1'b0;
                    res.drive_valid     = 1'b1;
                    res.outcome         = OC_STARTED;
                end
            end
        endcase

        res.done_res = st_next.done_flag;
    end

endmodule

@@ sv/step_settle_position_trimmer.sv @@
`timescale 1ns / 1ps
// Top level of the step-and-settle position trimmer: beat registers and state.
// Depends on sst_pkg, sst_cfg and sst_step.
//
// Every input beat (tick, range sample, path flag or start request) gives exactly one
// result beat. A beat is captured in an input register and resolved by the combinational
// update logic into the result register, so a new beat is taken every cycle while the
// result stream is not stalled; the result is presented from the result register and is
// taken by the downstream side when tready is high. The pipeline only stalls
// when the result register is full and the downstream side holds tready low. Write the
// configuration registers only while no beat is in flight.
module step_settle_position_trimmer
    import sst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [12:0] value, [15:13] zero
    input  logic [1:0]           s_tuser,   // [1:0] command
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [9:0] vel_x, [19:10] vel_y, [20] done_res,
                                            // [23:21] outcome
    output logic                 m_tuser    // [0] drive_valid
);

    cfg_t              cfg;
    state_t            st_reg;
    state_t            st_next;
    result_t           res_next;
    result_t           res_reg;
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DIST_W-1:0] value_reg;
    logic              out_valid_reg;
    logic              advance;

    sst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sst_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .command (cmd_reg),
        .value   (value_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Resolve the held beat when the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata[DIST_W-1:0];
        end
    end

    // Tuning state advances once per resolved beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.drive_valid;
    assign m_tdata  = {res_reg.outcome, res_reg.done_res, res_reg.vel_y, res_reg.vel_x};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for step_settle_position_trimmer: table-driven and random beats
// scored against an in-bench predictor of the tuning state machine. Depends on sst_pkg.
module tb;
    import sst_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam bit TYPED       = 1'b1;
    localparam bit PREDICT     = 1'b0;

    // Hand-written results for the directed table
    localparam result_t RES_IDLE      = '0;
    localparam result_t RES_IDLE_DONE = {1'b0, 10'd0, 10'd0, 1'b1, OC_NONE};
    localparam result_t RES_NO_DATA   = {1'b0, 10'd0, 10'd0, 1'b0, OC_NO_DATA};
    localparam result_t RES_BUSY      = {1'b0, 10'd0, 10'd0, 1'b0, OC_BUSY};
    localparam result_t RES_STARTED   = {1'b1, 10'd0, 10'd0, 1'b0, OC_STARTED};
    localparam int      DIR_ROWS      = 25;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DIST_W-1:0] val;
        logic              typed;
        result_t           res;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // [12:0] value, [15:13] zero
    logic [1:0]           s_tuser;   // [1:0] command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [9:0] vel_x, [19:10] vel_y, [20] done_res, [23:21] outcome
    logic                 m_tuser;   // [0] drive_valid

    // Predictor copy of the trimmer configuration and state
    cfg_t                trim_cfg;
    logic [PHASE_W-1:0]  st_phase;
    logic                st_path;
    logic                st_have;
    logic [DIST_W-1:0]   st_range;
    logic                st_moving;
    logic                st_settling;
    logic [TOTAL_W-1:0]  st_total;
    logic [CNT8_W-1:0]   st_pticks;
    logic [CNT8_W-1:0]   st_steps;
    logic [VEL_W-1:0]    st_hvx;
    logic [VEL_W-1:0]    st_hvy;
    logic                st_done;

    result_t trim_res_q[$];
    logic    row_typed;
    result_t row_res;
    int      err_cnt;
    int      chk_cnt;
    int      move_cnt;
    int      oc_cnt[0:7];
    int      n_settings;
    int      burst_left;
    int      hold_req;

    step_settle_position_trimmer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Build one result beat around the current finished flag
    function automatic result_t beat_out(input logic dv, input logic [VEL_W-1:0] vx,
                                         input logic [VEL_W-1:0] vy, input logic [OC_W-1:0] oc);
        result_t r;
        r.drive_valid = dv;
        r.vel_x       = vx;
        r.vel_y       = vy;
        r.done_res    = st_done;
        r.outcome     = oc;
        return r;
    endfunction

    function automatic void trim_enter();
        st_phase    = PH_TUNE;
        st_total    = '0;
        st_pticks   = '0;
        st_moving   = 1'b0;
        st_settling = 1'b1;
        st_hvx      = '0;
        st_hvy      = '0;
    endfunction

    function automatic result_t trim_finish(input logic [OC_W-1:0] oc);
        st_phase    = PH_DONE;
        st_moving   = 1'b0;
        st_settling = 1'b0;
        st_done     = 1'b1;
        return beat_out(1'b1, '0, '0, oc);
    endfunction

    // Advance the predicted trimmer by one input beat and return its result
    function automatic result_t trim_step(input logic [CMD_W-1:0] cmd,
                                          input logic [DIST_W-1:0] val);
        logic              err_pos;
        logic              fwd;
        logic [DIST_W-1:0] err_mag;
        logic [PROD_W-1:0] prod;
        logic [14:0]       spd;
        logic [VEL_W-1:0]  vel;
        case (cmd)
            CMD_TICK:
            begin
                if (st_phase != PH_TUNE)
                    return beat_out(1'b0, '0, '0, OC_NONE);
                if (st_total != 16'hFFFF)
                    st_total++;
                if (st_total > TIMEOUT_TICKS)
                    return trim_finish(OC_TIMEOUT);
                if (trim_cfg.step_limit != '0 && st_steps >= trim_cfg.step_limit)
                    return trim_finish(OC_STEP_LIM);
                // Hold the step speed until the move time runs out
                if (st_moving)
                begin
                    if (st_pticks != 8'hFF)
                        st_pticks++;
                    if (st_pticks >= trim_cfg.move_ticks)
                    begin
                        st_moving   = 1'b0;
                        st_settling = 1'b1;
                        st_pticks   = '0;
                        return beat_out(1'b1, '0, '0, OC_NONE);
                    end
                    return beat_out(1'b1, st_hvx, st_hvy, OC_NONE);
                end
                if (!st_settling)
                    return beat_out(1'b0, '0, '0, OC_NONE);
                if (st_pticks != 8'hFF)
                    st_pticks++;
                if (st_pticks < trim_cfg.settle_ticks || !st_have)
                    return beat_out(1'b1, '0, '0, OC_NONE);
                // Settled: compare range with target
                err_pos = st_range > trim_cfg.target_distance;
                err_mag = err_pos ? st_range - trim_cfg.target_distance
                                  : trim_cfg.target_distance - st_range;
                if (err_mag <= DIST_W'(trim_cfg.tolerance))
                    return trim_finish(OC_IN_TOL);
                prod = PROD_W'(trim_cfg.speed_gain) * PROD_W'(err_mag);
                spd  = prod[PROD_W-1:8];
                if (spd < 15'(MIN_SPEED))
                    spd = 15'(MIN_SPEED);
                if (spd > 15'(trim_cfg.max_speed))
                    spd = 15'(trim_cfg.max_speed);
                fwd = !trim_cfg.motion_mode[1];
                if (!err_pos)
                    fwd = !fwd;
                vel = fwd ? spd[9:0] : -spd[9:0];
                if (trim_cfg.motion_mode[0])
                begin
                    st_hvx = '0;
                    st_hvy = vel;
                end
                else
                begin
                    st_hvx = vel;
                    st_hvy = '0;
                end
                st_moving   = 1'b1;
                st_settling = 1'b0;
                st_pticks   = '0;
                if (st_steps != 8'hFF)
                    st_steps++;
                return beat_out(1'b1, st_hvx, st_hvy, OC_NONE);
            end
            CMD_SAMPLE:
            begin
                st_range = val;
                st_have  = 1'b1;
                if (st_path && st_phase == PH_IDLE)
                begin
                    trim_enter();
                    return beat_out(1'b1, '0, '0, OC_STARTED);
                end
                return beat_out(1'b0, '0, '0, OC_NONE);
            end
            CMD_PATH:
            begin
                // Only the first set flag counts
                if (val[0] && !st_path)
                begin
                    st_path = 1'b1;
                    if (st_phase == PH_IDLE && st_have)
                    begin
                        trim_enter();
                        return beat_out(1'b1, '0, '0, OC_STARTED);
                    end
                end
                return beat_out(1'b0, '0, '0, OC_NONE);
            end
            CMD_START:
            begin
                if (st_phase == PH_TUNE)
                    return beat_out(1'b0, '0, '0, OC_BUSY);
                if (!st_have)
                    return beat_out(1'b0, '0, '0, OC_NO_DATA);
                trim_enter();
                st_steps = '0;
                st_done  = 1'b0;
                return beat_out(1'b1, '0, '0, OC_STARTED);
            end
        endcase
        return RES_IDLE;
    endfunction

    // Directed table; hand-written results only where they are obvious
    function automatic dir_row_t dir_row(input int i);
        case (i)
            0:  return {CMD_TICK,   13'd0,    TYPED,   RES_IDLE};
            1:  return {CMD_START,  13'd0,    TYPED,   RES_NO_DATA};
            2:  return {CMD_PATH,   13'd0,    TYPED,   RES_IDLE};
            3:  return {CMD_PATH,   13'd8190, TYPED,   RES_IDLE};
            4:  return {CMD_PATH,   13'd1,    TYPED,   RES_IDLE};
            5:  return {CMD_SAMPLE, 13'd8191, TYPED,   RES_STARTED};
            6:  return {CMD_START,  13'd8191, TYPED,   RES_BUSY};
            7:  return {CMD_PATH,   13'd8191, TYPED,   RES_IDLE};
            8:  return {CMD_TICK,   13'd8191, PREDICT, RES_IDLE};
            9:  return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            10: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            11: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            12: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            13: return {CMD_SAMPLE, 13'd205,  PREDICT, RES_IDLE};
            14: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            15: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            16: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            17: return {CMD_TICK,   13'd0,    TYPED,   RES_IDLE_DONE};
            18: return {CMD_SAMPLE, 13'd0,    TYPED,   RES_IDLE_DONE};
            19: return {CMD_START,  13'd0,    TYPED,   RES_STARTED};
            20: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            21: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            22: return {CMD_TICK,   13'd0,    PREDICT, RES_IDLE};
            23: return {CMD_SAMPLE, 13'd190,  PREDICT, RES_IDLE};
            default: return {CMD_TICK, 13'd0, PREDICT, RES_IDLE};
        endcase
    endfunction

    function automatic cfg_t mk_cfg(input int tgt, input int tol, input int mode, input int mx,
                                    input int gain, input int lim, input int mv, input int st);
        cfg_t c;
        c.target_distance = DIST_W'(tgt);
        c.tolerance       = TOL_W'(tol);
        c.motion_mode     = MODE_W'(mode);
        c.max_speed       = SPEED_W'(mx);
        c.speed_gain      = GAIN_W'(gain);
        c.step_limit      = CNT8_W'(lim);
        c.move_ticks      = CNT8_W'(mv);
        c.settle_ticks    = CNT8_W'(st);
        return c;
    endfunction

    // Offer one beat, with a random gap once the current burst runs out
    task automatic put_beat(input logic [CMD_W-1:0] cmd, input logic [DIST_W-1:0] val,
                            input logic typed, input result_t res);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tuser  = 2'($urandom_range(0, 3));
            s_tdata  = {3'b000, 13'($urandom)};
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 32);
        end
        @(negedge clk);
        s_tvalid  = 1'b1;
        s_tuser   = cmd;
        s_tdata   = {3'b000, val};
        row_typed = typed;
        row_res   = res;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Drop valid and let every predicted result come back
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (trim_res_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        case (idx)
            REG_TARGET:   trim_cfg.target_distance = data[DIST_W-1:0];
            REG_TOL:      trim_cfg.tolerance       = data[TOL_W-1:0];
            REG_MODE:     trim_cfg.motion_mode     = data[MODE_W-1:0];
            REG_MAX_SPD:  trim_cfg.max_speed       = data[SPEED_W-1:0];
            REG_GAIN:     trim_cfg.speed_gain      = data[GAIN_W-1:0];
            REG_STEP_LIM: trim_cfg.step_limit      = data[CNT8_W-1:0];
            REG_MOVE:     trim_cfg.move_ticks      = data[CNT8_W-1:0];
            REG_SETTLE:   trim_cfg.settle_ticks    = data[CNT8_W-1:0];
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random tuning traffic: open with a start, then mostly ticks with samples, path flags and starts mixed in
    task automatic run_phase(input cfg_t c, input int n_items, input int tick_pct,
                             input int near_pct, input bit squeeze);
        int          k;
        int          pick;
        int          span;
        int          v;
        logic [1:0]  cmd;
        logic [12:0] val;
        drain();
        put_reg(REG_TARGET,   c.target_distance);
        put_reg(REG_TOL,      CFG_DAT_W'(c.tolerance));
        put_reg(REG_MODE,     CFG_DAT_W'(c.motion_mode));
        put_reg(REG_MAX_SPD,  CFG_DAT_W'(c.max_speed));
        put_reg(REG_GAIN,     CFG_DAT_W'(c.speed_gain));
        put_reg(REG_STEP_LIM, CFG_DAT_W'(c.step_limit));
        put_reg(REG_MOVE,     CFG_DAT_W'(c.move_ticks));
        put_reg(REG_SETTLE,   CFG_DAT_W'(c.settle_ticks));
        n_settings++;
        for (k = 0; k < n_items; k++)
        begin
            val  = 13'($urandom);
            pick = $urandom_range(0, 9);
            if (k == 0)
                cmd = CMD_START;
            else if ($urandom_range(0, 99) < tick_pct)
                cmd = CMD_TICK;
            else if (pick <= 5)
            begin
                cmd = CMD_SAMPLE;
                if ($urandom_range(0, 99) < near_pct)
                begin
                    // Land around the tolerance window edge
                    span = c.tolerance + 20;
                    v    = int'(c.target_distance) + int'($urandom_range(0, 2 * span)) - span;
                    val  = (v < 0) ? 13'd0 : (v > 8191) ? 13'd8191 : 13'(v);
                end
                else if ($urandom_range(0, 1) == 0)
                    val = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
            end
            else if (pick == 6)
                cmd = CMD_PATH;
            else
                cmd = CMD_START;
            put_beat(cmd, val, PREDICT, RES_IDLE);
            if (squeeze && k == 40)
                hold_req++;
        end
    endtask

    // Score output beats, then predict the beat taken at this edge
    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        result_t calc;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[9:0], m_tdata[19:10], m_tdata[20], m_tdata[23:21]};
            if (trim_res_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("tb: result beat with nothing expected: %h", got);
            end
            else
            begin
                want = trim_res_q.pop_front();
                chk_cnt++;
                oc_cnt[want.outcome]++;
                if (want.drive_valid && (want.vel_x != '0 || want.vel_y != '0))
                    move_cnt++;
                if (got.drive_valid !== want.drive_valid || got.vel_x !== want.vel_x ||
                    got.vel_y !== want.vel_y || got.done_res !== want.done_res ||
                    got.outcome !== want.outcome)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb: beat %0d exp dv=%0b vx=%0d vy=%0d done=%0b oc=%0d",
                                 chk_cnt, want.drive_valid, $signed(want.vel_x),
                                 $signed(want.vel_y), want.done_res, want.outcome,
                                 ", got dv=%0b vx=%0d vy=%0d done=%0b oc=%0d",
                                 got.drive_valid, $signed(got.vel_x), $signed(got.vel_y),
                                 got.done_res, got.outcome);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            calc = trim_step(s_tuser, s_tdata[12:0]);
            trim_res_q.push_back(row_typed ? row_res : calc);
        end
    end

    // Result side: stall patterns, plus long hold-offs on request
    initial
    begin : result_side
        int mode;
        int mode_left;
        int holds_done;
        mode       = 0;
        mode_left  = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int       i;
        dir_row_t row;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        row_typed  = 1'b0;
        row_res    = '0;
        err_cnt    = 0;
        chk_cnt    = 0;
        move_cnt   = 0;
        n_settings = 1;
        burst_left = 0;
        hold_req   = 0;
        for (i = 0; i < 8; i++)
            oc_cnt[i] = 0;
        trim_cfg    = mk_cfg(200, 10, 0, 50, 128, 50, 2, 3);
        st_phase    = PH_IDLE;
        st_path     = 1'b0;
        st_have     = 1'b0;
        st_range    = '0;
        st_moving   = 1'b0;
        st_settling = 1'b0;
        st_total    = '0;
        st_pticks   = '0;
        st_steps    = '0;
        st_hvx      = '0;
        st_hvy      = '0;
        st_done     = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under reset settings
        for (i = 0; i < DIR_ROWS - 1; i++)
        begin
            row = dir_row(i);
            put_beat(row.cmd, row.val, row.typed, row.res);
        end

        // Reset values, then both extremes, then forced timeouts and step limits, then one random setting
        run_phase(mk_cfg(200, 10, 0, 50, 128, 50, 2, 3), 120, 65, 60, 1'b1);
        run_phase(mk_cfg(0, 0, 3, 300, 1023, 255, 1, 0), 120, 70, 60, 1'b0);
        run_phase(mk_cfg(8191, 1023, 1, 10, 0, 1, 255, 255), 120, 90, 50, 1'b0);
        run_phase(mk_cfg(4000, 0, 2, 120, 300, 0, 1, 0), 350, 94, 0, 1'b1);
        run_phase(mk_cfg(1000, 5, 0, 200, 64, 3, 1, 1), 120, 80, 20, 1'b0);
        run_phase(mk_cfg($urandom_range(0, 8191), $urandom_range(0, 300),
                         $urandom_range(0, 3), $urandom_range(10, 300),
                         $urandom_range(0, 1023), $urandom_range(0, 20),
                         $urandom_range(1, 6), $urandom_range(0, 6)), 120, 70, 50, 1'b0);

        drain();
        repeat (8) @(negedge clk);
        $display("tb: %0d result beats over %0d register settings, %0d moving drive beats",
                 chk_cnt, n_settings, move_cnt);
        $display("tb: starts %0d, busy %0d, no-data %0d, in-tolerance %0d,",
                 oc_cnt[OC_STARTED], oc_cnt[OC_BUSY], oc_cnt[OC_NO_DATA], oc_cnt[OC_IN_TOL],
                 " timeout %0d, step-limit %0d",
                 oc_cnt[OC_TIMEOUT], oc_cnt[OC_STEP_LIM]);
        if (err_cnt == 0 && trim_res_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
